### rtl/repeat_string_instruction_unit_assert.svh
// Assertion macros for the repeat string instruction unit.
`ifndef REPEAT_STRING_INSTRUCTION_UNIT_ASSERT_SVH
`define REPEAT_STRING_INSTRUCTION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSIU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RSIU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RSIU_ASSERT(label, prop, msg)
`define RSIU_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### rtl/rsiu_pkg.sv
// ----------------------------------------------------------------------------
// rsiu_pkg
// Types and codes shared by the repeat string instruction unit.
// ----------------------------------------------------------------------------
package rsiu_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_MOVS = 3'd0, OP_CMPS = 3'd1, OP_STOS = 3'd2, OP_LODS = 3'd3, OP_SCAS = 3'd4
  } str_op_e;

  typedef enum logic [1:0] {
    KIND_RD_SRC = 2'd0, KIND_RD_DST = 2'd1, KIND_WR_DST = 2'd2, KIND_DONE = 2'd3
  } req_kind_e;

  localparam logic OPER_START = 1'b0;
  localparam logic OPER_RESP  = 1'b1;

  localparam logic CFG_SRC_BASE = 1'b0;
  localparam logic CFG_DST_BASE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [2:0]  string_op;
    logic [1:0]  element_size;
    logic        addr_32bit;
    logic        repeat_req;
    logic        repeat_while_equal;
    logic        direction_down;
    logic [31:0] source_index;
    logic [31:0] dest_index;
    logic [31:0] count;
    logic [31:0] accumulator;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  request_kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] final_source_index;
    logic [31:0] final_dest_index;
    logic [31:0] final_count;
    logic [31:0] accumulator_out;
    logic [31:0] compare_left;
    logic [31:0] compare_right;
    logic [31:0] compare_difference;
    logic        flags_update;
    logic        last;
  } out_item_t;

  // Item after classification by the front part.
  typedef struct packed {
    logic        is_start;
    logic        start_done;   // start that finishes at once
    logic [8:0]  mode;         // {down, rwe, rep, a32, size[1:0], op[2:0]}
    logic [31:0] src_idx;
    logic [31:0] dst_idx;
    logic [31:0] cnt;
    logic [31:0] acc;
    logic [31:0] data;
  } cls_item_t;

  function automatic logic [31:0] elem_mask(input logic [1:0] size);
    unique case (size)
      2'd0:    elem_mask = 32'h0000_00FF;
      2'd1:    elem_mask = 32'h0000_FFFF;
      default: elem_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] eff_val(input logic a32, input logic [31:0] v);
    eff_val = a32 ? v : {16'h0000, v[15:0]};
  endfunction

  function automatic logic [31:0] step_val(input logic a32, input logic down,
                                           input logic [31:0] v, input logic [31:0] d);
    logic [31:0] n;
    n = down ? v - d : v + d;
    step_val = a32 ? n : {v[31:16], n[15:0]};
  endfunction

endpackage

### rtl/rsiu_front.sv
// ----------------------------------------------------------------------------
// rsiu_front
// Accepts input items, decides whether a start finishes at once, and pushes
// the classified item into a short queue toward the execution part.
// ----------------------------------------------------------------------------
module rsiu_front import rsiu_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      q_valid_o,
  input  logic      q_pop_i,
  output cls_item_t q_item_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cls_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic push, pop;
  cls_item_t cls;

  always_comb begin
    cls.is_start   = (in_item_i.operation == OPER_START);
    cls.mode       = {in_item_i.direction_down, in_item_i.repeat_while_equal,
                      in_item_i.repeat_req, in_item_i.addr_32bit,
                      in_item_i.element_size, in_item_i.string_op};
    cls.start_done = (in_item_i.string_op > OP_SCAS) ||
                     (in_item_i.repeat_req &&
                      eff_val(in_item_i.addr_32bit, in_item_i.count) == 32'd0);
    cls.src_idx    = in_item_i.source_index;
    cls.dst_idx    = in_item_i.dest_index;
    cls.cnt        = in_item_i.count;
    cls.acc        = in_item_i.accumulator;
    cls.data       = in_item_i.read_data;
  end

  assign in_stall_o = (cnt_q == Depth[PtrW:0]);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

### rtl/rsiu_back.sv
// ----------------------------------------------------------------------------
// rsiu_back
// Carries out classified items: keeps the instruction registers, issues the
// next memory request or the done result into an output register.
// ----------------------------------------------------------------------------
`include "repeat_string_instruction_unit_assert.svh"
module rsiu_back import rsiu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  cls_item_t q_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);
  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_SRC, PH_WAIT_DST, PH_WAIT_WRITE} phase_e;

  phase_e      phase_q;
  logic [8:0]  mode_q;
  logic [31:0] si_q, di_q, cnt_q, acc_q, held_q, sbase_q, dbase_q;
  logic [31:0] cl_q, cr_q, cd_q;
  logic        cv_q;
  logic        ov_q;
  out_item_t   oi_q;

  // Working copies for this cycle.
  phase_e      ph;
  logic [8:0]  md;
  logic [31:0] si, di, cnt, acc, held, cl, cr, cd;
  logic        cv, emit;
  out_item_t   oi;

  logic        take;
  logic [2:0]  op;
  logic [1:0]  sz;
  logic [31:0] msk, data, delta;
  logic        a32, rep, rwe, dn, step_si, step_di, fin, cmpd, stop;

  assign take    = q_valid_i && (!ov_q || !out_stall_i);
  assign q_pop_o = take;

  always_comb begin
    ph = phase_q; md = mode_q; si = si_q; di = di_q; cnt = cnt_q; acc = acc_q;
    held = held_q; cl = cl_q; cr = cr_q; cd = cd_q; cv = cv_q;
    emit = 1'b0; oi = '0; fin = 1'b0; step_si = 1'b0; step_di = 1'b0; cmpd = 1'b0;
    stop = 1'b0;
    if (q_item_i.is_start) begin
      md = q_item_i.mode; si = q_item_i.src_idx; di = q_item_i.dst_idx;
      cnt = q_item_i.cnt; acc = q_item_i.acc; cv = 1'b0;
      cl = '0; cr = '0; cd = '0;
    end
    op  = md[2:0];
    sz  = (md[4:3] == 2'd3) ? 2'd2 : md[4:3];
    a32 = md[5]; rep = md[6]; rwe = md[7]; dn = md[8];
    msk = elem_mask(sz);
    delta = 32'd1 << sz;
    data = q_item_i.data & msk;
    if (q_item_i.is_start) begin
      emit = 1'b1;
      stop = q_item_i.start_done;
    end else begin
      unique case (phase_q)
        PH_WAIT_SRC: begin
          emit = 1'b1;
          if (op == OP_MOVS) begin
            ph = PH_WAIT_WRITE;
            oi.request_kind = KIND_WR_DST;
            oi.address = dbase_q + eff_val(a32, di);
            oi.write_data = data;
          end else if (op == OP_LODS) begin
            acc = (acc & ~msk) | data;
            fin = 1'b1; step_si = 1'b1;
          end else begin
            cl = data; cr = held & msk; cd = (data - (held & msk)) & msk; cv = 1'b1;
            fin = 1'b1; step_si = 1'b1; step_di = 1'b1; cmpd = 1'b1;
          end
        end
        PH_WAIT_DST: begin
          emit = 1'b1;
          if (op == OP_SCAS) begin
            cl = acc & msk; cr = data; cd = ((acc & msk) - data) & msk; cv = 1'b1;
            fin = 1'b1; step_di = 1'b1; cmpd = 1'b1;
          end else begin
            held = data;
            ph = PH_WAIT_SRC;
            oi.request_kind = KIND_RD_SRC;
            oi.address = sbase_q + eff_val(a32, si);
          end
        end
        PH_WAIT_WRITE: begin
          emit = 1'b1; fin = 1'b1; step_di = 1'b1; step_si = (op == OP_MOVS);
        end
        default: emit = 1'b0;
      endcase
    end
    if (fin) begin
      if (step_si) si = step_val(a32, dn, si, delta);
      if (step_di) di = step_val(a32, dn, di, delta);
      if (!rep) begin
        stop = 1'b1;
      end else begin
        cnt  = step_val(a32, 1'b1, cnt, 32'd1);
        stop = (eff_val(a32, cnt) == 32'd0) || (cmpd && ((cl == cr) != rwe));
      end
    end
    if (q_item_i.is_start || fin) begin
      if (stop) begin
        ph = PH_IDLE;
        oi.request_kind = KIND_DONE;
        oi.final_source_index = si;
        oi.final_dest_index = di;
        oi.final_count = cnt;
        oi.accumulator_out = acc;
        oi.compare_left = cv ? cl : '0;
        oi.compare_right = cv ? cr : '0;
        oi.compare_difference = cv ? cd : '0;
        oi.flags_update = cv;
        oi.last = 1'b1;
      end else if (op == OP_MOVS || op == OP_LODS) begin
        ph = PH_WAIT_SRC;
        oi.request_kind = KIND_RD_SRC;
        oi.address = sbase_q + eff_val(a32, si);
      end else if (op == OP_CMPS || op == OP_SCAS) begin
        ph = PH_WAIT_DST;
        oi.request_kind = KIND_RD_DST;
        oi.address = dbase_q + eff_val(a32, di);
      end else begin
        ph = PH_WAIT_WRITE;
        oi.request_kind = KIND_WR_DST;
        oi.address = dbase_q + eff_val(a32, di);
        oi.write_data = acc & msk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; mode_q <= '0; si_q <= '0; di_q <= '0; cnt_q <= '0;
      acc_q <= '0; cl_q <= '0; cr_q <= '0; cd_q <= '0; cv_q <= 1'b0;
      sbase_q <= '0; dbase_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SRC_BASE) sbase_q <= cfg_data_i;
        else dbase_q <= cfg_data_i;
      end
      if (take) begin
        phase_q <= ph; mode_q <= md; si_q <= si; di_q <= di; cnt_q <= cnt;
        acc_q <= acc; cl_q <= cl; cr_q <= cr; cd_q <= cd; cv_q <= cv;
        ov_q <= emit;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) held_q <= held;
    if (take && emit) oi_q <= oi;
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = oi_q;

  `RSIU_ASSERT_NEXT(a_stall_holds, ov_q && out_stall_i, ov_q && $stable(oi_q),
                    "output item changed under stall")
  `RSIU_ASSERT(a_done_idle, !(ov_q && oi_q.last) || phase_q == PH_IDLE,
               "done item while instruction still running")
  `RSIU_ASSERT(a_flags_done, !(ov_q && oi_q.flags_update) || oi_q.last,
               "flag update on a non-done item")
endmodule

### rtl/repeat_string_instruction_unit.sv
// ----------------------------------------------------------------------------
// repeat_string_instruction_unit
// Sequencer for repeated x86 string instructions.
// ----------------------------------------------------------------------------
// Usage: write the segment bases through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle. Send a start item (operation 0); the unit answers with the first
// memory request or, for a zero repeat count or unknown operation, with the
// done item. Each memory response item (operation 1) yields the next request
// or the done item, which carries the final registers and compare operands.
// Responses while idle give no item.
// An accepted item passes through the queue and then the output register.
// Throughput: one item per cycle while the output does not stall, set by
// the execute step in the back part. A two-entry queue decouples input from
// execution, so the input keeps flowing while the output register holds.
// When out_stall_i is high the output item holds and the queue fills; the
// input then stalls. Reset clears the state registers and the queue
// pointers, with no clearing pass.
// ----------------------------------------------------------------------------
module repeat_string_instruction_unit import rsiu_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);
  logic      q_valid, q_pop;
  cls_item_t q_item;

  rsiu_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  rsiu_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .out_item_o
  );
endmodule
